FILE: rtl/ssch_pkg.sv
// ----------------------------------------------------------------------------
// ssch_pkg: shared types and constants of the slotframe next-slot scheduler
// Field widths, mode and status codes, register indexes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssch_pkg;

	localparam int ID_W   = 16;
	localparam int LEN_W  = 16;
	localparam int OFS_W  = 16;
	localparam int ASN_W  = 53;
	localparam int TIME_W = 64;
	localparam int CELL_W = 16;
	localparam int REM_W  = LEN_W + 1;
	localparam int FULL_W = ASN_W + 1;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_FRAMES_DEF = 8;
	localparam int NUM_SLOTS_DEF  = 8;

	localparam logic [ASN_W-1:0]  ASN_MAX      = {ASN_W{1'b1}};
	localparam logic [CELL_W-1:0] CELL_RESET   = 16'd2500;
	localparam logic [TIME_W-1:0] PERIOD_RESET = 64'd18438809997803520000;

	// Narrow remainder unit: bits of the dividend retired per cycle.
	localparam int NMOD_BITS  = 4;
	localparam int NMOD_STEPS = (ASN_W + NMOD_BITS - 1) / NMOD_BITS;
	localparam int NMOD_PAD   = NMOD_STEPS * NMOD_BITS;

	typedef enum logic [1:0] {
		MODE_ADD_FRAME = 2'd0,
		MODE_ADD_SLOT  = 2'd1,
		MODE_DEL_SLOT  = 2'd2,
		MODE_QUERY     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_NONE     = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN = 2'd0,
		CFG_CELL   = 2'd1,
		CFG_PERIOD = 2'd2,
		CFG_SPARE  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic       load;
		logic       frd;
		logic       frd_owner;
		logic       fchk;
		logic       srd;
		logic       schk;
		logic       nstart;
		logic       nsel_ofs;
		logic       cap_ra;
		logic       cap_ro;
		logic       qcmp;
		logic       cap_full;
		logic       wstart;
		logic       wsel_full;
		logic       cap_ored;
		logic       cap_a;
		logic       mul_dbl;
		logic       mul_add;
		logic [3:0] bit_sel;
		logic       wr_frame;
		logic       wr_slot;
		logic       clr_slot;
		logic       emit;
		status_t    res_status;
		logic       res_query;
	} cmd_t;

	typedef struct packed {
		logic f_hit;
		logic f_free;
		logic s_match;
		logic s_free;
		logic s_used;
		logic fo_used;
		logic found;
		logic n_done;
		logic w_done;
	} stat_t;

endpackage

FILE: rtl/slotframe_next_slot_scheduler.sv
// ----------------------------------------------------------------------------
// slotframe_next_slot_scheduler: slotframe table with next-active-slot search
// Add frame, add slot, remove slot and next-slot query over a small frame
// table and a shared slot pool, one transaction at a time.
// ----------------------------------------------------------------------------
// Add frame scans the frame table; add or remove slot scans the frame table and then
// the slot pool; a query scans the slot pool, with two narrow remainders per
// scheduled slot whose frame is in use, and once a slot is found two bit-serial
// period reductions and a shift-and-add multiply.
// One transaction at a time; busy is high meanwhile; done lasts one cycle and the
// receiver cannot stall it. Reset clears all valid marks and loads register resets.
// ----------------------------------------------------------------------------
module slotframe_next_slot_scheduler #(
	parameter int NUM_FRAMES = ssch_pkg::NUM_FRAMES_DEF,
	parameter int NUM_SLOTS  = ssch_pkg::NUM_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel: a transaction is taken when start is high and busy low.
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     mode,
	input  logic [ssch_pkg::ID_W-1:0]      frame_id,
	input  logic [ssch_pkg::LEN_W-1:0]     frame_length,
	input  logic [ssch_pkg::OFS_W-1:0]     slot_index,
	input  logic [ssch_pkg::ASN_W-1:0]     query_asn,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [ssch_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssch_pkg::TIME_W-1:0]    cfg_data,
	// Result channel: one transaction per request, valid while done is high.
	output logic                           done,
	output logic [2:0]                     status,
	output logic [ssch_pkg::ID_W-1:0]      winner_frame,
	output logic [ssch_pkg::OFS_W-1:0]     winner_slot,
	output logic [ssch_pkg::ASN_W-1:0]     due_asn,
	output logic [ssch_pkg::TIME_W-1:0]    start_time_us
);
	import ssch_pkg::*;

	localparam int MAXN  = (NUM_FRAMES > NUM_SLOTS) ? NUM_FRAMES : NUM_SLOTS;
	localparam int IDX_W = (MAXN > 1) ? $clog2(MAXN) : 1;

	cmd_t             cmd;
	stat_t            stat;
	logic [IDX_W-1:0] idx;

	// The controller walks the frame table and slot pool through a shared
	// index; each entry is read into a register before it is checked.
	ssch_ctrl #(
		.NUM_FRAMES (NUM_FRAMES),
		.NUM_SLOTS  (NUM_SLOTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.idx    (idx),
		.busy   (busy)
	);

	// The datapath keeps the tables, the running best candidate (least
	// distance, then smaller frame id, then smaller offset) and the modular
	// arithmetic that turns the winning ASN into a start time.
	ssch_dp #(
		.NUM_FRAMES (NUM_FRAMES),
		.NUM_SLOTS  (NUM_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.idx           (idx),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.frame_id      (frame_id),
		.frame_length  (frame_length),
		.slot_index    (slot_index),
		.query_asn     (query_asn),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.winner_frame  (winner_frame),
		.winner_slot   (winner_slot),
		.due_asn       (due_asn),
		.start_time_us (start_time_us)
	);

endmodule

FILE: rtl/ssch_nmod.sv
// ----------------------------------------------------------------------------
// ssch_nmod: narrow iterative remainder unit
// Reduces a slot number modulo a frame length of up to 65536, retiring a few
// dividend bits per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module ssch_nmod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ssch_pkg::ASN_W-1:0] dividend,
	input  logic [ssch_pkg::REM_W-1:0] divisor,
	output logic                       done,
	output logic [ssch_pkg::REM_W-1:0] rem
);
	import ssch_pkg::*;

	localparam int CNT_W = $clog2(NMOD_STEPS + 1);

	logic [NMOD_PAD-1:0] sh_q;
	logic [REM_W-1:0]    rem_q;
	logic [REM_W-1:0]    div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic                done_q;
	logic [NMOD_PAD-1:0] sh_d;
	logic [REM_W-1:0]    rem_d;

	always_comb begin
		logic [REM_W:0] t;
		sh_d  = sh_q;
		rem_d = rem_q;
		for (int j = 0; j < NMOD_BITS; j++) begin
			t = {rem_d, sh_d[NMOD_PAD-1]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_d = t[REM_W-1:0];
			sh_d  = {sh_d[NMOD_PAD-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NMOD_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= NMOD_PAD'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			sh_q  <= sh_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/ssch_wmod.sv
// ----------------------------------------------------------------------------
// ssch_wmod: wide bit-serial remainder unit
// Reduces a 64-bit value modulo the timestamp period, one bit per cycle.
// A period of zero stands for 2^64 and returns the value unchanged.
// ----------------------------------------------------------------------------
module ssch_wmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ssch_pkg::TIME_W-1:0] dividend,
	input  logic [ssch_pkg::TIME_W-1:0] divisor,
	output logic                        done,
	output logic [ssch_pkg::TIME_W-1:0] rem
);
	import ssch_pkg::*;

	localparam int CNT_W = $clog2(TIME_W + 1);

	logic [TIME_W-1:0] sh_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [TIME_W:0]   t;
	logic [TIME_W:0]   t_sub;

	assign t     = {rem_q, sh_q[TIME_W-1]};
	assign t_sub = (t >= {1'b0, div_q}) ? t - {1'b0, div_q} : t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(TIME_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			sh_q  <= {sh_q[TIME_W-2:0], 1'b0};
			rem_q <= t_sub[TIME_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/ssch_dp.sv
// ----------------------------------------------------------------------------
// ssch_dp: scheduler datapath
// Holds the configuration, the frame table and slot pool, the scan flags, the
// distance compare, the modular start-time arithmetic and the result registers.
// ----------------------------------------------------------------------------
module ssch_dp #(
	parameter int NUM_FRAMES = ssch_pkg::NUM_FRAMES_DEF,
	parameter int NUM_SLOTS  = ssch_pkg::NUM_SLOTS_DEF,
	localparam int MAXN  = (NUM_FRAMES > NUM_SLOTS) ? NUM_FRAMES : NUM_SLOTS,
	localparam int IDX_W = (MAXN > 1) ? $clog2(MAXN) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ssch_pkg::cmd_t                 cmd,
	input  logic [IDX_W-1:0]               idx,
	input  logic                           cfg_we,
	input  logic [ssch_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssch_pkg::TIME_W-1:0]    cfg_data,
	input  logic [ssch_pkg::ID_W-1:0]      frame_id,
	input  logic [ssch_pkg::LEN_W-1:0]     frame_length,
	input  logic [ssch_pkg::OFS_W-1:0]     slot_index,
	input  logic [ssch_pkg::ASN_W-1:0]     query_asn,
	output ssch_pkg::stat_t                stat,
	output logic                           done,
	output logic [2:0]                     status,
	output logic [ssch_pkg::ID_W-1:0]      winner_frame,
	output logic [ssch_pkg::OFS_W-1:0]     winner_slot,
	output logic [ssch_pkg::ASN_W-1:0]     due_asn,
	output logic [ssch_pkg::TIME_W-1:0]    start_time_us
);
	import ssch_pkg::*;

	localparam int FIDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Configuration.
	logic [TIME_W-1:0] origin_q;
	logic [CELL_W-1:0] cell_q;
	logic [TIME_W-1:0] period_q;

	// Latched request.
	logic [ID_W-1:0]  fid_q;
	logic [LEN_W-1:0] flen_q;
	logic [OFS_W-1:0] sidx_q;
	logic [ASN_W-1:0] asn_q;

	// Tables.
	logic [NUM_FRAMES-1:0] frame_used_q;
	logic [NUM_SLOTS-1:0]  slot_used_q;
	logic [ID_W-1:0]       fid_mem  [NUM_FRAMES];
	logic [LEN_W-1:0]      fsz_mem  [NUM_FRAMES];
	logic [FIDX_W-1:0]     sown_mem [NUM_SLOTS];
	logic [OFS_W-1:0]      sofs_mem [NUM_SLOTS];
	logic [ID_W-1:0]       frd_id_q;
	logic [LEN_W-1:0]      frd_sz_q;
	logic [FIDX_W-1:0]     srd_own_q;
	logic [OFS_W-1:0]      srd_ofs_q;

	// Scan flags.
	logic              hit_q;
	logic [FIDX_W-1:0] hit_idx_q;
	logic              ffree_q;
	logic [FIDX_W-1:0] ffree_idx_q;
	logic              smatch_q;
	logic [SIDX_W-1:0] smatch_idx_q;
	logic              sfree_q;
	logic [SIDX_W-1:0] sfree_idx_q;

	// Query search.
	logic              found_q;
	logic [REM_W-1:0]  bd_q;
	logic [ID_W-1:0]   bid_q;
	logic [OFS_W-1:0]  bofs_q;
	logic [REM_W-1:0]  ra_q;
	logic [REM_W-1:0]  ro_q;
	logic [FULL_W-1:0] full_q;
	logic [TIME_W-1:0] ored_q;
	logic [TIME_W-1:0] a_q;
	logic [TIME_W-1:0] r_q;

	// Results.
	logic              done_q;
	status_t           status_q;
	logic [ID_W-1:0]   wf_q;
	logic [OFS_W-1:0]  ws_q;
	logic [ASN_W-1:0]  nasn_q;
	logic [TIME_W-1:0] tstart_q;

	logic [FIDX_W-1:0] fa;
	logic [SIDX_W-1:0] sa;
	logic [FIDX_W-1:0] faddr;
	logic [REM_W-1:0]  len;
	logic              n_done;
	logic [REM_W-1:0]  n_rem;
	logic              w_done;
	logic [TIME_W-1:0] w_rem;
	logic [REM_W:0]    d_wide;
	logic [REM_W-1:0]  fwd_dist;
	logic              better;
	logic [TIME_W-1:0] add_x;
	logic [TIME_W-1:0] add_y;
	logic [TIME_W:0]   add_sum;
	logic [TIME_W-1:0] add_res;
	logic              f_match;
	logic              s_match;

	assign fa    = idx[FIDX_W-1:0];
	assign sa    = idx[SIDX_W-1:0];
	assign faddr = cmd.frd_owner ? srd_own_q : fa;
	assign len   = (frd_sz_q == '0) ? REM_W'(1 << LEN_W) : {1'b0, frd_sz_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			cell_q   <= CELL_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ORIGIN: origin_q <= cfg_data;
				CFG_CELL:   cell_q   <= cfg_data[CELL_W-1:0];
				CFG_PERIOD: period_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fid_q  <= frame_id;
			flen_q <= frame_length;
			sidx_q <= slot_index;
			asn_q  <= query_asn;
		end
	end

	// Frame table and slot pool, with registered reads.
	always_ff @(posedge clk) begin
		if (cmd.wr_frame) begin
			fid_mem[ffree_idx_q] <= fid_q;
			fsz_mem[ffree_idx_q] <= flen_q;
		end
		if (cmd.frd) begin
			frd_id_q <= fid_mem[faddr];
			frd_sz_q <= fsz_mem[faddr];
		end
		if (cmd.wr_slot) begin
			sown_mem[sfree_idx_q] <= hit_idx_q;
			sofs_mem[sfree_idx_q] <= sidx_q;
		end
		if (cmd.srd) begin
			srd_own_q <= sown_mem[sa];
			srd_ofs_q <= sofs_mem[sa];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_used_q <= '0;
			slot_used_q  <= '0;
		end else begin
			if (cmd.wr_frame) begin
				frame_used_q[ffree_idx_q] <= 1'b1;
			end
			if (cmd.wr_slot) begin
				slot_used_q[sfree_idx_q] <= 1'b1;
			end
			if (cmd.clr_slot) begin
				slot_used_q[smatch_idx_q] <= 1'b0;
			end
		end
	end

	assign f_match = frame_used_q[fa] && (frd_id_q == fid_q);
	assign s_match = slot_used_q[sa] && (srd_own_q == hit_idx_q) && (srd_ofs_q == sidx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			ffree_q  <= 1'b0;
			smatch_q <= 1'b0;
			sfree_q  <= 1'b0;
			found_q  <= 1'b0;
		end else if (cmd.load) begin
			hit_q    <= 1'b0;
			ffree_q  <= 1'b0;
			smatch_q <= 1'b0;
			sfree_q  <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.fchk) begin
				if (!hit_q && f_match) begin
					hit_q <= 1'b1;
				end
				if (!ffree_q && !frame_used_q[fa]) begin
					ffree_q <= 1'b1;
				end
			end
			if (cmd.schk) begin
				if (!smatch_q && s_match) begin
					smatch_q <= 1'b1;
				end
				if (!sfree_q && !slot_used_q[sa]) begin
					sfree_q <= 1'b1;
				end
			end
			if (cmd.qcmp && better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fchk && !hit_q && f_match) begin
			hit_idx_q <= fa;
		end
		if (cmd.fchk && !ffree_q && !frame_used_q[fa]) begin
			ffree_idx_q <= fa;
		end
		if (cmd.schk && !smatch_q && s_match) begin
			smatch_idx_q <= sa;
		end
		if (cmd.schk && !sfree_q && !slot_used_q[sa]) begin
			sfree_idx_q <= sa;
		end
	end

	ssch_nmod u_nmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.nstart),
		.dividend (cmd.nsel_ofs ? ASN_W'(srd_ofs_q) : asn_q),
		.divisor  (len),
		.done     (n_done),
		.rem      (n_rem)
	);

	ssch_wmod u_wmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.wstart),
		.dividend (cmd.wsel_full ? TIME_W'(full_q) : origin_q),
		.divisor  (period_q),
		.done     (w_done),
		.rem      (w_rem)
	);

	// Forward distance from the reduced ASN to the reduced offset.
	assign d_wide   = (ro_q >= ra_q) ? {1'b0, ro_q} - {1'b0, ra_q}
	                                 : {1'b0, ro_q} + {1'b0, len} - {1'b0, ra_q};
	assign fwd_dist = d_wide[REM_W-1:0];
	assign better   = !found_q || (fwd_dist < bd_q) ||
	                  ((fwd_dist == bd_q) && (frd_id_q < bid_q)) ||
	                  ((fwd_dist == bd_q) && (frd_id_q == bid_q) && (srd_ofs_q < bofs_q));

	// Shared modular adder; both operands are already below the period.
	assign add_x   = cmd.emit ? ored_q : r_q;
	assign add_y   = cmd.mul_add ? a_q : r_q;
	assign add_sum = {1'b0, add_x} + {1'b0, add_y};
	always_comb begin
		if (period_q == '0) begin
			add_res = add_sum[TIME_W-1:0];
		end else if (add_sum >= {1'b0, period_q}) begin
			add_res = TIME_W'(add_sum - {1'b0, period_q});
		end else begin
			add_res = add_sum[TIME_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_ra) begin
			ra_q <= n_rem;
		end
		if (cmd.cap_ro) begin
			ro_q <= n_rem;
		end
		if (cmd.qcmp && better) begin
			bd_q   <= fwd_dist;
			bid_q  <= frd_id_q;
			bofs_q <= srd_ofs_q;
		end
		if (cmd.cap_full) begin
			full_q <= FULL_W'(asn_q) + FULL_W'(bd_q);
		end
		if (cmd.cap_ored) begin
			ored_q <= w_rem;
		end
		if (cmd.cap_a) begin
			a_q <= w_rem;
			r_q <= '0;
		end else if (cmd.mul_dbl) begin
			r_q <= add_res;
		end else if (cmd.mul_add && cell_q[cmd.bit_sel]) begin
			r_q <= add_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.res_status;
			wf_q     <= '0;
			ws_q     <= '0;
			nasn_q   <= '0;
			tstart_q <= '0;
			if (cmd.res_query && (cmd.res_status == ST_OK)) begin
				wf_q     <= bid_q;
				ws_q     <= bofs_q;
				nasn_q   <= full_q[FULL_W-1] ? ASN_MAX : full_q[ASN_W-1:0];
				tstart_q <= add_res;
			end else if (cmd.res_query) begin
				tstart_q <= '1;
			end
		end
	end

	assign stat.f_hit   = hit_q;
	assign stat.f_free  = ffree_q;
	assign stat.s_match = smatch_q;
	assign stat.s_free  = sfree_q;
	assign stat.s_used  = slot_used_q[sa];
	assign stat.fo_used = frame_used_q[srd_own_q];
	assign stat.found   = found_q;
	assign stat.n_done  = n_done;
	assign stat.w_done  = w_done;

	assign done          = done_q;
	assign status        = status_q;
	assign winner_frame  = wf_q;
	assign winner_slot   = ws_q;
	assign due_asn       = nasn_q;
	assign start_time_us = tstart_q;

endmodule

FILE: rtl/ssch_ctrl.sv
// ----------------------------------------------------------------------------
// ssch_ctrl: scheduler controller
// Sequences table scans, the per-slot distance computation and the modular
// start-time multiply, and issues one result per request.
// ----------------------------------------------------------------------------
module ssch_ctrl #(
	parameter int NUM_FRAMES = ssch_pkg::NUM_FRAMES_DEF,
	parameter int NUM_SLOTS  = ssch_pkg::NUM_SLOTS_DEF,
	localparam int MAXN  = (NUM_FRAMES > NUM_SLOTS) ? NUM_FRAMES : NUM_SLOTS,
	localparam int IDX_W = (MAXN > 1) ? $clog2(MAXN) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       mode,
	input  ssch_pkg::stat_t  stat,
	output ssch_pkg::cmd_t   cmd,
	output logic [IDX_W-1:0] idx,
	output logic             busy
);
	import ssch_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_FRD   = 16'h0002,
		S_FCHK  = 16'h0004,
		S_FPOST = 16'h0008,
		S_SRD   = 16'h0010,
		S_SCHK  = 16'h0020,
		S_SPOST = 16'h0040,
		S_QF    = 16'h0080,
		S_QWA   = 16'h0100,
		S_QWO   = 16'h0200,
		S_QCMP  = 16'h0400,
		S_QPOST = 16'h0800,
		S_TOW   = 16'h1000,
		S_TFW   = 16'h2000,
		S_TMUL  = 16'h4000,
		S_TFIN  = 16'h8000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	mode_t            mode_q, mode_d;
	logic [3:0]       bit_q, bit_d;
	logic             ph_q, ph_d;
	logic             last_f;
	logic             last_s;

	assign last_f = (idx_q == IDX_W'(NUM_FRAMES - 1));
	assign last_s = (idx_q == IDX_W'(NUM_SLOTS - 1));

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		mode_d      = mode_q;
		bit_d       = bit_q;
		ph_d        = ph_q;
		cmd         = '0;
		cmd.bit_sel = bit_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					mode_d   = mode_t'(mode);
					idx_d    = '0;
					state_d  = (mode_t'(mode) == MODE_QUERY) ? S_SRD : S_FRD;
				end
			end
			S_FRD: begin
				cmd.frd = 1'b1;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				cmd.fchk = 1'b1;
				if (last_f) begin
					state_d = S_FPOST;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = S_FRD;
				end
			end
			S_FPOST: begin
				if (mode_q == MODE_ADD_FRAME) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
					if (stat.f_hit) begin
						cmd.res_status = ST_DUP;
					end else if (stat.f_free) begin
						cmd.wr_frame   = 1'b1;
						cmd.res_status = ST_OK;
					end else begin
						cmd.res_status = ST_FULL;
					end
				end else if (!stat.f_hit) begin
					cmd.emit       = 1'b1;
					cmd.res_status = ST_NOTFOUND;
					state_d        = S_IDLE;
				end else begin
					idx_d   = '0;
					state_d = S_SRD;
				end
			end
			S_SRD: begin
				cmd.srd = 1'b1;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (mode_q == MODE_QUERY) begin
					if (stat.s_used) begin
						cmd.frd       = 1'b1;
						cmd.frd_owner = 1'b1;
						state_d       = S_QF;
					end else if (last_s) begin
						state_d = S_QPOST;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = S_SRD;
					end
				end else begin
					cmd.schk = 1'b1;
					if (last_s) begin
						state_d = S_SPOST;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = S_SRD;
					end
				end
			end
			S_SPOST: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
				if (mode_q == MODE_ADD_SLOT) begin
					if (stat.s_match) begin
						cmd.res_status = ST_DUP;
					end else if (stat.s_free) begin
						cmd.wr_slot    = 1'b1;
						cmd.res_status = ST_OK;
					end else begin
						cmd.res_status = ST_FULL;
					end
				end else if (stat.s_match) begin
					cmd.clr_slot   = 1'b1;
					cmd.res_status = ST_OK;
				end else begin
					cmd.res_status = ST_NOTFOUND;
				end
			end
			S_QF: begin
				if (stat.fo_used) begin
					cmd.nstart = 1'b1;
					state_d    = S_QWA;
				end else if (last_s) begin
					state_d = S_QPOST;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = S_SRD;
				end
			end
			S_QWA: begin
				if (stat.n_done) begin
					cmd.cap_ra   = 1'b1;
					cmd.nstart   = 1'b1;
					cmd.nsel_ofs = 1'b1;
					state_d      = S_QWO;
				end
			end
			S_QWO: begin
				if (stat.n_done) begin
					cmd.cap_ro = 1'b1;
					state_d    = S_QCMP;
				end
			end
			S_QCMP: begin
				cmd.qcmp = 1'b1;
				if (last_s) begin
					state_d = S_QPOST;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = S_SRD;
				end
			end
			S_QPOST: begin
				if (!stat.found) begin
					cmd.emit       = 1'b1;
					cmd.res_status = ST_NONE;
					cmd.res_query  = 1'b1;
					state_d        = S_IDLE;
				end else begin
					cmd.cap_full = 1'b1;
					cmd.wstart   = 1'b1;
					state_d      = S_TOW;
				end
			end
			S_TOW: begin
				if (stat.w_done) begin
					cmd.cap_ored  = 1'b1;
					cmd.wstart    = 1'b1;
					cmd.wsel_full = 1'b1;
					state_d       = S_TFW;
				end
			end
			S_TFW: begin
				if (stat.w_done) begin
					cmd.cap_a = 1'b1;
					bit_d     = 4'd15;
					ph_d      = 1'b0;
					state_d   = S_TMUL;
				end
			end
			S_TMUL: begin
				if (!ph_q) begin
					cmd.mul_dbl = 1'b1;
					ph_d        = 1'b1;
				end else begin
					cmd.mul_add = 1'b1;
					ph_d        = 1'b0;
					if (bit_q == 4'd0) begin
						state_d = S_TFIN;
					end else begin
						bit_d = bit_q - 4'd1;
					end
				end
			end
			S_TFIN: begin
				cmd.emit       = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_query  = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			mode_q  <= MODE_ADD_FRAME;
			bit_q   <= '0;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			mode_q  <= mode_d;
			bit_q   <= bit_d;
			ph_q    <= ph_d;
		end
	end

	assign idx  = idx_q;
	assign busy = (state_q != S_IDLE);

endmodule
